### hdl/handheld_bus_address_decoder_unit_macros.svh
// assertion helpers shared by the decoder unit
`ifndef HANDHELD_BUS_ADDRESS_DECODER_UNIT_MACROS_SVH
`define HANDHELD_BUS_ADDRESS_DECODER_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define HBAD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define HBAD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/hbad_pkg.sv
`default_nettype none

package hbad_pkg;

    localparam int ADDR_W   = 16;
    localparam int OFFSET_W = 22;

    // command targets
    localparam logic [3:0] TGT_ROM    = 4'd0;
    localparam logic [3:0] TGT_VRAM   = 4'd1;
    localparam logic [3:0] TGT_CRAM   = 4'd2;
    localparam logic [3:0] TGT_FLAT   = 4'd3;
    localparam logic [3:0] TGT_OAM    = 4'd4;
    localparam logic [3:0] TGT_IO     = 4'd5;
    localparam logic [3:0] TGT_HRAM   = 4'd6;
    localparam logic [3:0] TGT_DIRECT = 4'd7;
    localparam logic [3:0] TGT_ABSORB = 4'd8;

    // controller types
    localparam logic [1:0] MBC_NONE = 2'd0;
    localparam logic [1:0] MBC_CTRL = 2'd3;

    localparam logic [0:0] OP_READ  = 1'b0;
    localparam logic [0:0] OP_WRITE = 1'b1;

    localparam logic [3:0] CRAM_ENABLE_KEY = 4'hA;
    localparam logic [7:0] JOYPAD_FIXED    = 8'hC0;

    localparam logic [ADDR_W-1:0] ADDR_RAM_EN_END = 16'h2000;
    localparam logic [ADDR_W-1:0] ADDR_ROMX       = 16'h4000;
    localparam logic [ADDR_W-1:0] ADDR_RAMB_END   = 16'h6000;
    localparam logic [ADDR_W-1:0] ADDR_VRAM       = 16'h8000;
    localparam logic [ADDR_W-1:0] ADDR_CRAM       = 16'hA000;
    localparam logic [ADDR_W-1:0] ADDR_WRAM       = 16'hC000;
    localparam logic [ADDR_W-1:0] ADDR_WRAM_NOMIR = 16'hDE00;
    localparam logic [ADDR_W-1:0] ADDR_ECHO       = 16'hE000;
    localparam logic [ADDR_W-1:0] ADDR_OAM        = 16'hFE00;
    localparam logic [ADDR_W-1:0] ADDR_UNUSABLE   = 16'hFEA0;
    localparam logic [ADDR_W-1:0] ADDR_JOYPAD     = 16'hFF00;
    localparam logic [ADDR_W-1:0] ADDR_HRAM       = 16'hFF80;
    localparam logic [ADDR_W-1:0] ADDR_IE         = 16'hFFFF;
    localparam logic [ADDR_W-1:0] ECHO_DISTANCE   = 16'h2000;

    typedef struct packed {
        logic [0:0]        opcode;
        logic [ADDR_W-1:0] address;
        logic [7:0]        write_data;
        logic [7:0]        button_state;
    } item_t;

    typedef struct packed {
        logic [7:0] rom_bank_select;
        logic [7:0] ram_bank_select;
        logic       cart_ram_enabled;
        logic [3:0] joypad_select;
        logic [7:0] interrupt_enable;
    } regs_t;

    typedef struct packed {
        logic [3:0]          target;
        logic [OFFSET_W-1:0] offset;
        logic                is_write;
        logic [7:0]          data;
        logic                last;
    } cmd_t;

endpackage

`default_nettype wire

### hdl/hbad_decode.sv
`default_nettype none

module hbad_decode (
    input  wire hbad_pkg::item_t  item,
    input  wire                   phase,
    input  wire [1:0]             mbc_type,
    input  wire hbad_pkg::regs_t  regs,
    output hbad_pkg::cmd_t        cmd,
    output logic                  dual,
    output hbad_pkg::regs_t       regs_next
);
    import hbad_pkg::*;

    logic [ADDR_W-1:0] a;
    logic              wr;
    logic [7:0]        dat;
    logic [7:0]        bank;
    logic [3:0]        pressed;

    always_comb
    begin
        a    = item.address;
        wr   = (item.opcode == OP_WRITE);
        dat  = wr ? item.write_data : 8'd0;
        // a bank select of zero maps bank one
        bank = (regs.rom_bank_select == 8'd0) ? 8'd1 : regs.rom_bank_select;

        pressed = 4'd0;
        if (!regs.joypad_select[0])
        begin
            pressed = pressed | item.button_state[3:0];
        end
        if (!regs.joypad_select[1])
        begin
            pressed = pressed | item.button_state[7:4];
        end

        cmd          = '0;
        cmd.last     = 1'b1;
        dual         = 1'b0;
        regs_next    = regs;

        if (a < ADDR_VRAM)
        begin
            if (!wr)
            begin
                cmd.target = TGT_ROM;
                if (a < ADDR_ROMX || mbc_type == MBC_NONE)
                begin
                    cmd.offset = {6'd0, a};
                end
                else
                begin
                    cmd.offset = {bank, a[13:0]};
                end
            end
            else
            begin
                cmd.target = TGT_ABSORB;
                if (mbc_type == MBC_CTRL)
                begin
                    if (a < ADDR_RAM_EN_END)
                    begin
                        regs_next.cart_ram_enabled = (item.write_data[3:0] == CRAM_ENABLE_KEY);
                    end
                    else if (a < ADDR_ROMX)
                    begin
                        regs_next.rom_bank_select = item.write_data;
                    end
                    else if (a < ADDR_RAMB_END)
                    begin
                        regs_next.ram_bank_select = item.write_data;
                    end
                end
            end
        end
        else if (a < ADDR_CRAM)
        begin
            cmd.target   = TGT_VRAM;
            cmd.offset   = {9'd0, a[12:0]};
            cmd.is_write = wr;
            cmd.data     = dat;
        end
        else if (a < ADDR_WRAM)
        begin
            cmd.is_write = wr;
            cmd.data     = dat;
            if (mbc_type != MBC_NONE && regs.cart_ram_enabled)
            begin
                cmd.target = TGT_CRAM;
                cmd.offset = {1'b0, regs.ram_bank_select, a[12:0]};
            end
            else
            begin
                cmd.target = TGT_FLAT;
                cmd.offset = {6'd0, a};
            end
        end
        else if (a < ADDR_OAM)
        begin
            cmd.target   = TGT_FLAT;
            cmd.is_write = wr;
            cmd.data     = dat;
            cmd.offset   = {6'd0, a};
            // work ram writes below 0xDE00 and echo writes hit both copies, bus address first
            if (wr && (a < ADDR_WRAM_NOMIR || a >= ADDR_ECHO))
            begin
                dual = 1'b1;
                if (!phase)
                begin
                    cmd.last = 1'b0;
                end
                else if (a < ADDR_WRAM_NOMIR)
                begin
                    cmd.offset = {6'd0, a + ECHO_DISTANCE};
                end
                else
                begin
                    cmd.offset = {6'd0, a - ECHO_DISTANCE};
                end
            end
        end
        else if (a < ADDR_UNUSABLE)
        begin
            cmd.target   = TGT_OAM;
            cmd.offset   = {14'd0, a[7:0]};
            cmd.is_write = wr;
            cmd.data     = dat;
        end
        else if (a < ADDR_JOYPAD)
        begin
            cmd.target = wr ? TGT_ABSORB : TGT_DIRECT;
        end
        else if (a == ADDR_JOYPAD)
        begin
            if (wr)
            begin
                cmd.target              = TGT_ABSORB;
                regs_next.joypad_select = item.write_data[7:4];
            end
            else
            begin
                cmd.target = TGT_DIRECT;
                // buttons read active low
                cmd.data   = JOYPAD_FIXED | {2'b00, regs.joypad_select[1:0], ~pressed};
            end
        end
        else if (a < ADDR_HRAM)
        begin
            cmd.target   = TGT_IO;
            cmd.offset   = {14'd0, a[7:0]};
            cmd.is_write = wr;
            cmd.data     = dat;
        end
        else if (a < ADDR_IE)
        begin
            cmd.target   = TGT_HRAM;
            cmd.offset   = {15'd0, a[6:0]};
            cmd.is_write = wr;
            cmd.data     = dat;
        end
        else
        begin
            if (wr)
            begin
                cmd.target                 = TGT_ABSORB;
                regs_next.interrupt_enable = item.write_data;
            end
            else
            begin
                cmd.target = TGT_DIRECT;
                cmd.data   = regs.interrupt_enable;
            end
        end
    end

endmodule

`default_nettype wire

### hdl/handheld_bus_address_decoder_unit.sv
// Bus address decoder for a handheld console with a banked cartridge controller.
// Input channel (in_valid / in_stall): one CPU bus access per beat, carrying
// opcode, address, write_data and button_state. Output channel (out_valid /
// out_stall): one memory command per beat with target, offset, is_write, data
// and last; last marks the final command of an access.
// An accepted access is registered in the input stage, then its first command in
// the output register. Single-command accesses can follow back to back while the
// output is not stalled; a work-ram write below 0xDE00 or an echo write makes two
// commands and holds the input register until its second command is emitted.
// The user must write the cartridge controller type via cfg_wr_en / cfg_wr_data
// only while the unit is idle; the unit itself does not enforce this.
// Reset clears the controller type, bank, ram-enable, joypad-select and
// interrupt-enable registers and empties both stages. While out_stall is high
// the held command stays put, and the input stage fills and then raises
// in_stall until the output moves again.
`default_nettype none

module handheld_bus_address_decoder_unit (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_wr_en,
    input  wire  [1:0]  cfg_wr_data,
    input  wire         in_valid,
    output logic        in_stall,
    input  wire  [0:0]  opcode,
    input  wire  [15:0] address,
    input  wire  [7:0]  write_data,
    input  wire  [7:0]  button_state,
    output logic        out_valid,
    input  wire         out_stall,
    output logic [3:0]  target,
    output logic [21:0] offset,
    output logic        is_write,
    output logic [7:0]  data,
    output logic        last
);
    import hbad_pkg::*;

    `include "handheld_bus_address_decoder_unit_macros.svh"

    item_t      s1_item_reg;
    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic       s1_phase_reg;
    logic       s1_phase_next;
    regs_t      regs_reg;
    regs_t      regs_next;
    logic [1:0] mbc_type_reg;
    cmd_t       out_cmd_reg;
    logic       out_valid_reg;
    logic       out_valid_next;

    cmd_t       cmd;
    logic       dual;
    logic       out_load;
    logic       emit;
    logic       s1_done;
    logic       in_fire;
    item_t      in_item;

    assign in_item.opcode       = opcode;
    assign in_item.address      = address;
    assign in_item.write_data   = write_data;
    assign in_item.button_state = button_state;

    hbad_decode u_decode (
        .item      (s1_item_reg),
        .phase     (s1_phase_reg),
        .mbc_type  (mbc_type_reg),
        .regs      (regs_reg),
        .cmd       (cmd),
        .dual      (dual),
        .regs_next (regs_next)
    );

    assign out_load = !out_valid_reg || !out_stall;
    assign emit     = s1_valid_reg && out_load;
    // the access leaves the input stage with its last command
    assign s1_done  = emit && (!dual || s1_phase_reg);
    assign in_stall = s1_valid_reg && !s1_done;
    assign in_fire  = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_phase_next = s1_phase_reg;
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
            s1_phase_next = 1'b0;
        end
        else if (s1_done)
        begin
            s1_valid_next = 1'b0;
            s1_phase_next = 1'b0;
        end
        else if (emit && dual)
        begin
            s1_phase_next = 1'b1;
        end

        out_valid_next = out_load ? emit : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_phase_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            regs_reg      <= '0;
            mbc_type_reg  <= MBC_NONE;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s1_phase_reg  <= s1_phase_next;
            out_valid_reg <= out_valid_next;
            if (s1_done)
            begin
                regs_reg <= regs_next;
            end
            if (cfg_wr_en)
            begin
                mbc_type_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_item_reg <= in_item;
        end
        if (emit)
        begin
            out_cmd_reg <= cmd;
        end
    end

    assign out_valid = out_valid_reg;
    assign target    = out_cmd_reg.target;
    assign offset    = out_cmd_reg.offset;
    assign is_write  = out_cmd_reg.is_write;
    assign data      = out_cmd_reg.data;
    assign last      = out_cmd_reg.last;

    // first half of a mirrored write always has its second half waiting behind it
    `HBAD_ASSERT_NOW(a_pair_pending, clk, rst_n,
        out_valid_reg && !out_cmd_reg.last,
        s1_valid_reg && s1_phase_reg,
        "mirror write lost its second command")
    // second half follows right after the first is taken
    `HBAD_ASSERT_NEXT(a_pair_back_to_back, clk, rst_n,
        out_valid_reg && !out_stall && !out_cmd_reg.last,
        out_valid_reg && out_cmd_reg.last,
        "mirror write pair split")
    // control registers move only as an access completes
    `HBAD_ASSERT_NEXT(a_regs_hold, clk, rst_n,
        !s1_done,
        $stable(regs_reg),
        "control register changed without a completed access")

endmodule

`default_nettype wire

### dv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import hbad_pkg::*;

    // controller types that only bank, without taking control writes
    localparam logic [1:0] MBC_BANK1 = 2'd1;
    localparam logic [1:0] MBC_BANK2 = 2'd2;

    localparam int CYCLE_LIMIT = 200000;

    logic        clk;
    logic        rst_n        = 1'b0;
    logic        cfg_wr_en    = 1'b0;
    logic [1:0]  cfg_wr_data  = 2'd0;
    logic        in_valid     = 1'b0;
    logic [0:0]  opcode       = OP_READ;
    logic [15:0] address      = 16'h0000;
    logic [7:0]  write_data   = 8'h00;
    logic [7:0]  button_state = 8'h00;
    logic        out_stall    = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic [3:0]  target;
    logic [21:0] offset;
    logic        is_write;
    logic [7:0]  data;
    logic        last;

    // decoder state as the bus should see it
    logic [1:0]  mbc_kind  = MBC_NONE;
    logic [7:0]  rom_bank  = 8'h00;
    logic [7:0]  ram_bank  = 8'h00;
    logic        cram_on   = 1'b0;
    logic [3:0]  joy_sel   = 4'h0;
    logic [7:0]  ie_reg    = 8'h00;

    item_t access_q[$];
    cmd_t  pending_cmds[$];
    item_t next_access;
    cmd_t  want;

    int issued        = 0;
    int accepted      = 0;
    int mismatches    = 0;
    int cycles        = 0;
    int send_idle_pct = 23;
    int recv_idle_pct = 23;
    bit sender_hold   = 1'b0;
    bit in_taken      = 1'b0;

    handheld_bus_address_decoder_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .address      (address),
        .write_data   (write_data),
        .button_state (button_state),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .target       (target),
        .offset       (offset),
        .is_write     (is_write),
        .data         (data),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic expect_cmd(input logic [3:0] tgt, input logic [21:0] off,
                              input logic wr, input logic [7:0] dat, input logic lst);
        cmd_t c;
        c.target   = tgt;
        c.offset   = off;
        c.is_write = wr;
        c.data     = dat;
        c.last     = lst;
        pending_cmds.push_back(c);
    endtask

    // turns one bus access into the commands it should produce
    task automatic decode_access(input logic [0:0] op, input logic [15:0] a,
                                 input logic [7:0] d, input logic [7:0] btn);
        logic        wr;
        logic [7:0]  wdata;
        logic [7:0]  bank;
        logic [3:0]  pressed;
        logic [21:0] cram_off;
        wr = (op == OP_WRITE);
        wdata = wr ? d : 8'h00;
        cram_off = {6'd0, a - ADDR_CRAM} + {1'b0, ram_bank, 13'd0};
        if (a < ADDR_VRAM)
        begin
            if (!wr)
            begin
                if (a < ADDR_ROMX || mbc_kind == MBC_NONE)
                    expect_cmd(TGT_ROM, {6'd0, a}, 1'b0, 8'h00, 1'b1);
                else
                begin
                    // bank zero in the switchable window maps bank one
                    bank = (rom_bank != 8'h00) ? rom_bank : 8'h01;
                    expect_cmd(TGT_ROM, {6'd0, a - ADDR_ROMX} + {bank, 14'd0},
                               1'b0, 8'h00, 1'b1);
                end
            end
            else
            begin
                if (mbc_kind == MBC_CTRL)
                begin
                    if (a < ADDR_RAM_EN_END)
                        cram_on = (d[3:0] == CRAM_ENABLE_KEY);
                    else if (a < ADDR_ROMX)
                        rom_bank = d;
                    else if (a < ADDR_RAMB_END)
                        ram_bank = d;
                end
                expect_cmd(TGT_ABSORB, 22'd0, 1'b0, 8'h00, 1'b1);
            end
        end
        else if (a < ADDR_CRAM)
            expect_cmd(TGT_VRAM, {6'd0, a - ADDR_VRAM}, wr, wdata, 1'b1);
        else if (a < ADDR_WRAM)
        begin
            if (mbc_kind != MBC_NONE && cram_on)
                expect_cmd(TGT_CRAM, cram_off, wr, wdata, 1'b1);
            else
                expect_cmd(TGT_FLAT, {6'd0, a}, wr, wdata, 1'b1);
        end
        else if (a < ADDR_OAM)
        begin
            if (wr && a < ADDR_WRAM_NOMIR)
            begin
                expect_cmd(TGT_FLAT, {6'd0, a}, 1'b1, d, 1'b0);
                expect_cmd(TGT_FLAT, {6'd0, a + ECHO_DISTANCE}, 1'b1, d, 1'b1);
            end
            else if (wr && a >= ADDR_ECHO)
            begin
                expect_cmd(TGT_FLAT, {6'd0, a}, 1'b1, d, 1'b0);
                expect_cmd(TGT_FLAT, {6'd0, a - ECHO_DISTANCE}, 1'b1, d, 1'b1);
            end
            else
                expect_cmd(TGT_FLAT, {6'd0, a}, wr, wdata, 1'b1);
        end
        else if (a < ADDR_UNUSABLE)
            expect_cmd(TGT_OAM, {6'd0, a - ADDR_OAM}, wr, wdata, 1'b1);
        else if (a < ADDR_JOYPAD)
        begin
            if (wr)
                expect_cmd(TGT_ABSORB, 22'd0, 1'b0, 8'h00, 1'b1);
            else
                expect_cmd(TGT_DIRECT, 22'd0, 1'b0, 8'h00, 1'b1);
        end
        else if (a == ADDR_JOYPAD)
        begin
            if (wr)
            begin
                joy_sel = d[7:4];
                expect_cmd(TGT_ABSORB, 22'd0, 1'b0, 8'h00, 1'b1);
            end
            else
            begin
                // buttons read back active low, per selected group
                pressed = 4'h0;
                if (!joy_sel[0])
                    pressed = pressed | btn[3:0];
                if (!joy_sel[1])
                    pressed = pressed | btn[7:4];
                expect_cmd(TGT_DIRECT, 22'd0, 1'b0,
                           JOYPAD_FIXED | {2'b00, joy_sel[1:0], ~pressed}, 1'b1);
            end
        end
        else if (a < ADDR_HRAM)
            expect_cmd(TGT_IO, {6'd0, a - ADDR_JOYPAD}, wr, wdata, 1'b1);
        else if (a < ADDR_IE)
            expect_cmd(TGT_HRAM, {6'd0, a - ADDR_HRAM}, wr, wdata, 1'b1);
        else
        begin
            if (wr)
            begin
                ie_reg = d;
                expect_cmd(TGT_ABSORB, 22'd0, 1'b0, 8'h00, 1'b1);
            end
            else
                expect_cmd(TGT_DIRECT, 22'd0, 1'b0, ie_reg, 1'b1);
        end
    endtask

    function automatic item_t random_access();
        item_t       acc;
        int          pick;
        logic [15:0] edge_addr;
        acc.opcode       = $urandom_range(0, 1);
        acc.address      = $urandom;
        acc.write_data   = $urandom;
        acc.button_state = $urandom;
        edge_addr        = 16'h0000;
        pick = $urandom_range(0, 99);
        if (pick < 18)
        begin
            // controller commands, with the ram key and small banks favored
            acc.opcode  = OP_WRITE;
            acc.address = $urandom_range(0, ADDR_VRAM - 1);
            if ($urandom_range(0, 1) == 1)
                acc.write_data[3:0] = CRAM_ENABLE_KEY;
            else if ($urandom_range(0, 2) == 0)
                acc.write_data = $urandom_range(0, 3);
        end
        else if (pick < 30)
        begin
            acc.opcode  = OP_READ;
            acc.address = $urandom_range(ADDR_ROMX, ADDR_VRAM - 1);
        end
        else if (pick < 44)
            acc.address = $urandom_range(ADDR_CRAM, ADDR_WRAM - 1);
        else if (pick < 58)
        begin
            acc.address = $urandom_range(ADDR_WRAM, ADDR_OAM - 1);
            if (pick < 52)
                acc.opcode = OP_WRITE;
        end
        else if (pick < 64)
            acc.address = ADDR_JOYPAD;
        else if (pick < 68)
            acc.address = ADDR_IE;
        else if (pick < 80)
        begin
            case ($urandom_range(0, 13))
                0:  edge_addr = 16'h0000;
                1:  edge_addr = ADDR_RAM_EN_END;
                2:  edge_addr = ADDR_ROMX;
                3:  edge_addr = ADDR_RAMB_END;
                4:  edge_addr = ADDR_VRAM;
                5:  edge_addr = ADDR_CRAM;
                6:  edge_addr = ADDR_WRAM;
                7:  edge_addr = ADDR_WRAM_NOMIR;
                8:  edge_addr = ADDR_ECHO;
                9:  edge_addr = ADDR_OAM;
                10: edge_addr = ADDR_UNUSABLE;
                11: edge_addr = ADDR_JOYPAD;
                12: edge_addr = ADDR_HRAM;
                default: edge_addr = ADDR_IE;
            endcase
            acc.address = edge_addr - $urandom_range(0, 1);
        end
        return acc;
    endfunction

    task automatic queue_access(input logic [0:0] op, input logic [15:0] a,
                                input logic [7:0] d, input logic [7:0] btn);
        item_t acc;
        acc.opcode       = op;
        acc.address      = a;
        acc.write_data   = d;
        acc.button_state = btn;
        access_q.push_back(acc);
        issued++;
    endtask

    task automatic wait_quiet();
        while (accepted != issued || pending_cmds.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_controller(input logic [1:0] kind);
        wait_quiet();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= kind;
        mbc_kind = kind;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_random(input logic [1:0] kind, input int count, input int idle_pct);
        item_t acc;
        set_controller(kind);
        send_idle_pct = idle_pct;
        recv_idle_pct = idle_pct;
        for (int i = 0; i < count; i++)
        begin
            acc = random_access();
            queue_access(acc.opcode, acc.address, acc.write_data, acc.button_state);
        end
        // halfway through, hold the sender until the output has drained
        while (access_q.size() > count / 2)
            @(posedge clk);
        sender_hold = 1'b1;
        while (in_valid || pending_cmds.size() != 0)
            @(negedge clk);
        sender_hold = 1'b0;
    endtask

    // input side: predict on accept, present new beats on the falling edge
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            decode_access(opcode, address, write_data, button_state);
            accepted++;
            in_taken = 1'b1;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_taken)
        begin
            in_taken = 1'b0;
            if (access_q.size() != 0 && !sender_hold
                && $urandom_range(0, 99) >= send_idle_pct)
            begin
                next_access = access_q.pop_front();
                opcode       <= next_access.opcode;
                address      <= next_access.address;
                write_data   <= next_access.write_data;
                button_state <= next_access.button_state;
                in_valid     <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
        out_stall <= rst_n && ($urandom_range(0, 99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_cmds.size() == 0)
            begin
                $error("unexpected command beat: target %0d offset 0x%0h", target, offset);
                mismatches++;
            end
            else
            begin
                want = pending_cmds.pop_front();
                if (target !== want.target)
                begin
                    $error("target: expected %0d, got %0d", want.target, target);
                    mismatches++;
                end
                if (offset !== want.offset)
                begin
                    $error("offset: expected 0x%0h, got 0x%0h", want.offset, offset);
                    mismatches++;
                end
                if (is_write !== want.is_write)
                begin
                    $error("is_write: expected %0d, got %0d", want.is_write, is_write);
                    mismatches++;
                end
                if (data !== want.data)
                begin
                    $error("data: expected 0x%0h, got 0x%0h", want.data, data);
                    mismatches++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, last);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("handheld_bus_address_decoder_unit verification failed");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no controller: every region at least once, mirrors, joypad and ie
        queue_access(OP_READ,  16'h0000, 8'h00, 8'h00);
        queue_access(OP_READ,  16'h7FFF, 8'h00, 8'h00);
        queue_access(OP_WRITE, 16'h2000, 8'h55, 8'h00);
        queue_access(OP_WRITE, 16'h8000, 8'hA5, 8'h00);
        queue_access(OP_READ,  16'h9FFF, 8'hFF, 8'h00);
        queue_access(OP_READ,  16'hA000, 8'h00, 8'h00);
        queue_access(OP_WRITE, 16'hBFFF, 8'h3C, 8'h00);
        queue_access(OP_WRITE, 16'hC000, 8'h81, 8'h00);
        queue_access(OP_WRITE, 16'hDDFF, 8'h7E, 8'h00);
        queue_access(OP_WRITE, 16'hDE00, 8'h11, 8'h00);
        queue_access(OP_WRITE, 16'hDFFF, 8'h22, 8'h00);
        queue_access(OP_WRITE, 16'hE000, 8'h33, 8'h00);
        queue_access(OP_WRITE, 16'hFDFF, 8'h44, 8'h00);
        queue_access(OP_READ,  16'hE123, 8'h00, 8'h00);
        queue_access(OP_WRITE, 16'hFE00, 8'h99, 8'h00);
        queue_access(OP_READ,  16'hFE9F, 8'h00, 8'h00);
        queue_access(OP_READ,  16'hFEA0, 8'h00, 8'hFF);
        queue_access(OP_WRITE, 16'hFEFF, 8'h12, 8'h00);
        queue_access(OP_WRITE, 16'hFF00, 8'h20, 8'h00);
        queue_access(OP_READ,  16'hFF00, 8'h00, 8'h5A);
        queue_access(OP_WRITE, 16'hFF01, 8'hFF, 8'h00);
        queue_access(OP_READ,  16'hFF7F, 8'h00, 8'h00);
        queue_access(OP_WRITE, 16'hFF80, 8'h01, 8'h00);
        queue_access(OP_READ,  16'hFFFE, 8'h00, 8'h00);
        queue_access(OP_WRITE, 16'hFFFF, 8'hFF, 8'h00);
        queue_access(OP_READ,  16'hFFFF, 8'h00, 8'h00);

        // full controller: ram enable, bank zero, bank extremes, 0x6000-0x7FFF writes, joypad groups
        set_controller(MBC_CTRL);
        queue_access(OP_WRITE, 16'h0000, 8'h0A, 8'h00);
        queue_access(OP_WRITE, 16'h2000, 8'h00, 8'h00);
        queue_access(OP_READ,  16'h4000, 8'h00, 8'h00);
        queue_access(OP_WRITE, 16'h3FFF, 8'hFF, 8'h00);
        queue_access(OP_READ,  16'h7FFF, 8'h00, 8'h00);
        queue_access(OP_WRITE, 16'h4000, 8'hFF, 8'h00);
        queue_access(OP_READ,  16'hA000, 8'h00, 8'h00);
        queue_access(OP_WRITE, 16'hBFFF, 8'h77, 8'h00);
        queue_access(OP_WRITE, 16'h6000, 8'h01, 8'h00);
        queue_access(OP_WRITE, 16'h7FFF, 8'h00, 8'h00);
        queue_access(OP_WRITE, 16'h1FFF, 8'h0B, 8'h00);
        queue_access(OP_READ,  16'hA000, 8'h00, 8'h00);
        queue_access(OP_WRITE, 16'h5FFF, 8'h00, 8'h00);
        queue_access(OP_WRITE, 16'h0000, 8'hFA, 8'h00);
        queue_access(OP_READ,  16'hBFFF, 8'h00, 8'h00);
        queue_access(OP_WRITE, 16'hFF00, 8'h10, 8'h00);
        queue_access(OP_READ,  16'hFF00, 8'h00, 8'hFF);
        queue_access(OP_WRITE, 16'hFF00, 8'h30, 8'h00);
        queue_access(OP_READ,  16'hFF00, 8'h00, 8'hFF);
        queue_access(OP_WRITE, 16'hFF00, 8'h00, 8'h00);
        queue_access(OP_READ,  16'hFF00, 8'h00, 8'hA5);
        queue_access(OP_WRITE, 16'hFFFF, 8'h00, 8'h00);
        queue_access(OP_READ,  16'hFFFF, 8'h00, 8'h00);

        run_random(MBC_CTRL,  500, 23);
        run_random(MBC_CTRL,  300, 0);
        run_random(MBC_BANK1, 300, 23);
        run_random(MBC_BANK2, 250, 23);
        run_random(MBC_NONE,  250, 23);
        run_random(MBC_CTRL,  250, 23);

        wait_quiet();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("handheld_bus_address_decoder_unit verification clean");
        else
            $display("handheld_bus_address_decoder_unit verification failed");
        $finish;
    end

endmodule
